// File: hw/rtl/rse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants for the rotation spline evaluator
// Segment count, fixed-point widths, the table address split and the
// command format that the front end hands to the back end.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int SEGMENTS       = 4;
  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_W         = 20;
  localparam int SEG_W          = 2;
  localparam int QBITS          = 28;
  localparam int COEF_WORDS     = 12;
  localparam int MAT_WORDS      = 9;
  localparam int COEF_DEPTH     = SEGMENTS * COEF_WORDS;
  localparam int MAT_DEPTH      = SEGMENTS * MAT_WORDS;
  localparam int COEF_AW        = $clog2(COEF_DEPTH);
  localparam int MAT_AW         = $clog2(MAT_DEPTH);
  localparam int KW             = TIME_W - TIME_FRAC_BITS;

  localparam logic [1:0] ST_WRITTEN = 2'd0;
  localparam logic [1:0] ST_EVAL    = 2'd1;
  localparam logic [1:0] ST_PASTEND = 2'd2;
  localparam logic [1:0] ST_ZERO    = 2'd3;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EVAL,
    CMD_PAST
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      wr_coef;
    logic                      wr_mat;
    logic [COEF_AW-1:0]        coef_addr;
    logic [MAT_AW-1:0]         mat_addr;
    logic signed [31:0]        value;
    logic [SEG_W-1:0]          seg;
    logic [TIME_FRAC_BITS:0]   tau;
  } cmd_t;

  typedef logic signed [31:0] word_t;

endpackage

// File: hw/rtl/rse_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_front: input classification
// Decodes each input beat into a write, evaluate or past-end command and works out
// the segment and local time.
// ----------------------------------------------------------------------------
module rse_front (
  input  logic                          in_func,
  input  logic [1:0]                    in_segment,
  input  logic [4:0]                    in_word_index,
  input  logic signed [31:0]            in_word_value,
  input  logic [rse_pkg::TIME_W-1:0]    in_time_q16,
  output rse_pkg::cmd_t                 cmd
);
  import rse_pkg::*;

  logic [TIME_W-1:0] tm1;
  logic [KW-1:0]     k;
  logic [TIME_W-1:0] kshift;
  logic [TIME_W-1:0] tau_full;
  logic              seg_ok;
  logic [6:0]        cidx;
  logic [6:0]        midx;

  always_comb begin
    tm1      = in_time_q16 - TIME_W'(1);
    k        = (in_time_q16 == '0) ? '0 : tm1[TIME_W-1:TIME_FRAC_BITS];
    kshift   = TIME_W'(k) << TIME_FRAC_BITS;
    tau_full = in_time_q16 - kshift;
    seg_ok   = 32'(in_segment) < SEGMENTS;
    cidx     = 7'(in_segment) * 7'(COEF_WORDS) + 7'(in_word_index);
    midx     = 7'(in_segment) * 7'(MAT_WORDS) + 7'(in_word_index) - 7'(COEF_WORDS);

    cmd           = '0;
    cmd.value     = in_word_value;
    cmd.coef_addr = cidx[COEF_AW-1:0];
    cmd.mat_addr  = midx[MAT_AW-1:0];
    cmd.seg       = k[SEG_W-1:0];
    cmd.tau       = tau_full[TIME_FRAC_BITS:0];
    if (!in_func) begin
      cmd.kind    = CMD_WRITE;
      cmd.wr_coef = seg_ok && (in_word_index < 5'(COEF_WORDS));
      cmd.wr_mat  = seg_ok && (in_word_index >= 5'(COEF_WORDS))
                    && (in_word_index < 5'(COEF_WORDS + MAT_WORDS));
    end else if (32'(k) >= SEGMENTS) begin
      cmd.kind = CMD_PAST;
    end else begin
      cmd.kind = CMD_EVAL;
    end
  end

endmodule

// File: hw/rtl/rse_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_queue: two-entry command queue
// Decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rse_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rse_pkg::cmd_t  push_data,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output rse_pkg::cmd_t  head
);
  import rse_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = mem_r[rp_r];

  // advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  assert property (@(posedge clk) disable iff (!rst_n) !not_empty |-> !pop)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");

endmodule

// File: hw/rtl/rse_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_back: spline evaluation engine
// Sequencer around one shared 33x33 multiplier and a bit-serial divider;
// owns the coefficient and base-matrix memories and the held matrix.
// ----------------------------------------------------------------------------
module rse_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  rse_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output rse_pkg::word_t out_mat [rse_pkg::MAT_WORDS],
  output logic [1:0]     out_status
);
  import rse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_T2, S_T3, S_X, S_P, S_TH, S_DIV, S_R, S_OUT
  } state_t;

  state_t state_r;

  word_t coef_mem [COEF_DEPTH];
  word_t mat_mem  [MAT_DEPTH];
  word_t rd_r;

  word_t held_r [MAT_WORDS];
  word_t res_r  [MAT_WORDS];
  logic [1:0] status_r;

  logic [SEG_W-1:0] seg_r;
  logic signed [32:0] t1_r, t2_r, t3_r;
  word_t x_r [4];
  logic signed [63:0] p_r [10];
  logic signed [63:0] acc_r;
  logic signed [63:0] th_r [MAT_WORDS];
  logic signed [31:0] q_r [MAT_WORDS];
  logic [5:0] i_r;
  logic [1:0] ph_r;
  logic [1:0] rr_r, rc_r;
  logic signed [65:0] mul_q;

  // divider state
  logic [63:0] dr_r;
  logic [63:0] dd_r;
  logic [28:0] dq_r;
  logic        dneg_r;
  logic [4:0]  dn_r;
  logic [3:0]  di_r;

  logic [63:0] n2;
  assign n2 = 64'(p_r[0] + p_r[4] + p_r[7] + p_r[9]);

  function automatic logic signed [63:0] fl28(input logic signed [65:0] v);
    fl28 = 64'(v >>> QBITS);
  endfunction

  function automatic word_t sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  // read address and ratio select for sequenced memory reads
  logic [COEF_AW-1:0] caddr;
  logic [MAT_AW-1:0]  maddr;
  logic [3:0]         qsel;
  always_comb begin
    caddr = COEF_AW'(32'(seg_r) * COEF_WORDS + 32'(i_r[3:0]));
    maddr = MAT_AW'(32'(seg_r) * MAT_WORDS + 32'(rr_r) * 3
                    + 32'((ph_r == 2'd3) ? 2'd0 : ph_r));
    qsel  = 4'(rc_r) + ((ph_r == 2'd2) ? 4'd3 : (ph_r == 2'd3) ? 4'd6 : 4'd0);
  end

  // multiplier operand select
  logic signed [32:0] ma, mb;
  logic [1:0] xi, xj;
  always_comb begin
    ma = t1_r; mb = t1_r;
    xi = 2'd0; xj = 2'd0;
    unique case (state_r)
      S_T2: begin ma = t1_r; mb = t1_r; end
      S_T3: begin ma = t2_r; mb = t1_r; end
      S_X: begin
        ma = 33'(rd_r);
        mb = (ph_r == 2'd1) ? t3_r : (ph_r == 2'd2) ? t2_r : t1_r;
      end
      S_P: begin
        xi = (i_r < 6'd4) ? 2'd0 : (i_r < 6'd7) ? 2'd1 : (i_r < 6'd9) ? 2'd2 : 2'd3;
        xj = 2'((i_r < 6'd4) ? i_r : (i_r < 6'd7) ? i_r - 6'd3 :
                (i_r < 6'd9) ? i_r - 6'd5 : 6'd3);
        ma = 33'(x_r[xi]); mb = 33'(x_r[xj]);
      end
      S_R: begin ma = 33'(rd_r); mb = 33'(q_r[qsel]); end
      default: begin ma = t1_r; mb = t1_r; end
    endcase
    mul_q = 66'(ma) * 66'(mb);
  end

  assign cmd_pop   = (state_r == S_IDLE) && cmd_valid;
  assign out_valid = state_r == S_OUT;
  assign out_mat   = res_r;
  assign out_status = status_r;

  logic signed [63:0] thv;
  logic [63:0] thabs;

  // pick the dividend for the current ratio
  always_comb begin
    thv   = th_r[di_r];
    thabs = thv[63] ? 64'(-thv) : 64'(thv);
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_WRITE) begin
      if (cmd.wr_coef) coef_mem[cmd.coef_addr] <= cmd.value;
      if (cmd.wr_mat)  mat_mem[cmd.mat_addr]   <= cmd.value;
    end
    if (state_r == S_X) rd_r <= coef_mem[caddr];
    else rd_r <= mat_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= ST_WRITTEN;
      for (int m = 0; m < MAT_WORDS; m++) held_r[m] <= '0;
      i_r <= '0; ph_r <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (cmd_pop) begin
          seg_r <= cmd.seg;
          t1_r  <= 33'(cmd.tau) <<< (QBITS - TIME_FRAC_BITS);
          i_r   <= '0; ph_r <= '0;
          acc_r <= '0;
          unique case (cmd.kind)
            CMD_WRITE: begin
              for (int m = 0; m < MAT_WORDS; m++) res_r[m] <= '0;
              status_r <= ST_WRITTEN; state_r <= S_OUT;
            end
            CMD_PAST: begin
              res_r <= held_r; status_r <= ST_PASTEND; state_r <= S_OUT;
            end
            default: state_r <= S_T2;
          endcase
        end
        S_T2: begin t2_r <= 33'(fl28(mul_q)); state_r <= S_T3; end
        S_T3: begin t3_r <= 33'(fl28(mul_q)); state_r <= S_X; end
        // walk c-words: ph 0 issues read, 1..3 multiply a,b,c
        S_X: begin
          if (ph_r == 2'd3) begin
            x_r[i_r[1:0]] <= sat32(acc_r + fl28(mul_q) +
                                   ((i_r[1:0] == 2'd3) ? 64'sd268435456 : 64'sd0));
            acc_r <= '0; ph_r <= '0;
            if (i_r[1:0] == 2'd3) begin i_r <= '0; state_r <= S_P; end
            else i_r <= i_r - 6'd8 + 6'd1;
          end else begin
            if (ph_r != 2'd0) acc_r <= acc_r + fl28(mul_q);
            ph_r <= ph_r + 2'd1;
            i_r  <= (ph_r == 2'd0) ? i_r + 6'd4 : (ph_r == 2'd1) ? i_r + 6'd4 : i_r;
          end
        end
        S_P: begin
          p_r[i_r[3:0]] <= 64'(mul_q >>> 2);
          if (i_r == 6'd9) state_r <= S_TH; else i_r <= i_r + 6'd1;
        end
        S_TH: begin
          if (n2 == 64'd0) begin
            res_r <= held_r; status_r <= ST_ZERO; state_r <= S_OUT;
          end else begin
            th_r[0] <= p_r[9] + p_r[0] - p_r[4] - p_r[7];
            th_r[1] <= 2 * (p_r[1] - p_r[8]);
            th_r[2] <= 2 * (p_r[2] + p_r[6]);
            th_r[3] <= 2 * (p_r[1] + p_r[8]);
            th_r[4] <= p_r[9] - p_r[0] + p_r[4] - p_r[7];
            th_r[5] <= 2 * (p_r[5] - p_r[3]);
            th_r[6] <= 2 * (p_r[2] - p_r[6]);
            th_r[7] <= 2 * (p_r[5] + p_r[3]);
            th_r[8] <= p_r[9] - p_r[0] - p_r[4] + p_r[7];
            dd_r <= n2; di_r <= '0; dn_r <= 5'd31;
            state_r <= S_DIV;
          end
        end
        // restoring division, one quotient bit per cycle
        S_DIV: begin
          if (dn_r == 5'd31) begin
            if (thabs >= dd_r) begin dr_r <= '0; dq_r <= 29'd1; end
            else begin dr_r <= thabs; dq_r <= '0; end
            dneg_r <= thv[63];
            dn_r <= 5'd0;
          end else if (dn_r < 5'(QBITS)) begin
            if ({dr_r, 1'b0} >= {1'b0, dd_r}) begin
              dr_r <= 64'({dr_r, 1'b0} - {1'b0, dd_r}); dq_r <= {dq_r[27:0], 1'b1};
            end else begin
              dr_r <= {dr_r[62:0], 1'b0}; dq_r <= {dq_r[27:0], 1'b0};
            end
            dn_r <= dn_r + 5'd1;
          end else begin
            q_r[di_r] <= dneg_r ? -32'(dq_r) : 32'(dq_r);
            dn_r <= 5'd31;
            if (di_r == 4'd8) begin
              di_r <= '0; i_r <= '0; ph_r <= '0; acc_r <= '0;
              rr_r <= '0; rc_r <= '0;
              state_r <= S_R;
            end else di_r <= di_r + 4'd1;
          end
        end
        // R(r,c): ph 0 read, 1..3 accumulate base(r,m)*q(m,c), then floor
        S_R: begin
          if (ph_r == 2'd3) begin
            res_r[i_r[3:0]]  <= sat32(fl28(66'(acc_r) + mul_q));
            held_r[i_r[3:0]] <= sat32(fl28(66'(acc_r) + mul_q));
            acc_r <= '0; ph_r <= '0;
            if (rc_r == 2'd2) begin rc_r <= '0; rr_r <= rr_r + 2'd1; end
            else rc_r <= rc_r + 2'd1;
            if (i_r == 6'd8) begin
              status_r <= ST_EVAL; state_r <= S_OUT;
            end else i_r <= i_r + 6'd1;
          end else begin
            if (ph_r != 2'd0) acc_r <= acc_r + 64'(mul_q);
            ph_r <= ph_r + 2'd1;
          end
        end
        default: begin
          if (out_ready) state_r <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> $past(state_r) != S_OUT || !$past(out_valid) || $past(out_ready))
    else $error("command taken while result pending");
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dn_r <= 5'(QBITS) || dn_r == 5'd31)
    else $error("divider step out of range");

endmodule

// File: hw/rtl/rotation_spline_evaluator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_spline_evaluator: four-segment cubic quaternion spline
// Channel  | direction | handshake
// in_      | input     | in_valid / in_ready
// out_     | output    | out_valid / out_ready
// Write and past-end beats go from idle straight to the output state; evaluate
// beats run through the bit-serial divider (9 ratios) and the shared multiplier
// (x terms, products, matrix); zero norm skips the divider, returns the held matrix.
// Reset is synchronous; held matrix clears, tables stay undefined.
// A stalled output holds the back end; the two-entry queue takes two more beats.
// ----------------------------------------------------------------------------
module rotation_spline_evaluator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_func,
  input  logic [1:0]                  in_segment,
  input  logic [4:0]                  in_word_index,
  input  logic signed [31:0]          in_word_value,
  input  logic [rse_pkg::TIME_W-1:0]  in_time_q16,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [31:0]          out_r00, out_r01, out_r02,
  output logic signed [31:0]          out_r10, out_r11, out_r12,
  output logic signed [31:0]          out_r20, out_r21, out_r22,
  output logic [1:0]                  out_status
);
  import rse_pkg::*;

  cmd_t  fcmd, qhead;
  logic  qfull, qne, qpop;
  word_t mat [MAT_WORDS];

  rse_front u_front (
    .in_func, .in_segment, .in_word_index, .in_word_value, .in_time_q16,
    .cmd(fcmd)
  );

  assign in_ready = !qfull;

  rse_queue u_queue (
    .clk, .rst_n, .push(in_valid && in_ready), .push_data(fcmd), .full(qfull),
    .pop(qpop), .not_empty(qne), .head(qhead)
  );

  rse_back u_back (
    .clk, .rst_n, .cmd_valid(qne), .cmd(qhead), .cmd_pop(qpop),
    .out_valid, .out_ready, .out_mat(mat), .out_status
  );

  assign out_r00 = mat[0];
  assign out_r01 = mat[1];
  assign out_r02 = mat[2];
  assign out_r10 = mat[3];
  assign out_r11 = mat[4];
  assign out_r12 = mat[5];
  assign out_r20 = mat[6];
  assign out_r21 = mat[7];
  assign out_r22 = mat[8];

endmodule
